/* src/bba_pkg.sv */
package bba_pkg;

  // Bitmap storage word: one bit per block, 32 blocks per word.
  localparam int WORD_BITS = 32;
  localparam int WORD_SHIFT = 5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT,
    S_ALLOC_FIN,
    S_FREE_LV,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_LARGE     = 3'd1,
    ST_OVER_CAPACITY = 3'd2,
    ST_NO_BLOCK      = 3'd3,
    ST_NOT_ALLOCATED = 3'd4
  } status_t;

  // Classification of a request, decided by the front end.
  typedef struct packed {
    logic is_free;  // 1 = free request, 0 = allocate
    logic reject;   // alloc: size too large; free: address beyond the space
  } cls_t;

endpackage

/* src/bba_front.sv */
module bba_front #(
  parameter int LEAF_BLOCKS     = 1024,
  parameter int LEVELS          = 11,
  parameter int MIN_BLOCK_BYTES = 1024
) (
  input  logic                               command,
  input  logic [31:0]                        request_size,
  input  logic [19:0]                        block_address,
  output bba_pkg::cls_t                      cls,
  output logic [$clog2(LEVELS)-1:0]          want,
  output logic [$clog2(LEAF_BLOCKS)-1:0]     leaf
);

  localparam int LXW = $clog2(LEVELS);
  localparam int LIW = $clog2(LEAF_BLOCKS);
  localparam int MW  = $clog2(MIN_BLOCK_BYTES);

  logic [LEVELS-1:0] fits;
  logic [LXW-1:0]    want_lv;
  logic [63:0]       leaf_full;

  // Block size compare per level, all in parallel.
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      fits[l] = ({32'd0, request_size} <= (64'(MIN_BLOCK_BYTES) << l));
    end
  end

  // Lowest level that holds the request.
  always_comb begin
    want_lv = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (fits[l]) begin
        want_lv = LXW'(l);
      end
    end
  end

  assign leaf_full = {44'd0, block_address} >> MW;

  always_comb begin
    cls.is_free = command;
    if (command) begin
      cls.reject = (leaf_full >= 64'(LEAF_BLOCKS));
      want       = '0;
    end else begin
      cls.reject = !fits[LEVELS-1];
      want       = want_lv;
    end
    leaf = leaf_full[LIW-1:0];
  end

endmodule

/* src/bba_fifo.sv */
module bba_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  // Two-entry queue between classifier and sequencer.
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

/* src/bba_back.sv */
module bba_back #(
  parameter int LEAF_BLOCKS     = 1024,
  parameter int LEVELS          = 11,
  parameter int MIN_BLOCK_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  output logic                           clearing,
  input  logic                           q_valid,
  input  bba_pkg::cls_t                  q_cls,
  input  logic [$clog2(LEVELS)-1:0]      q_want,
  input  logic [$clog2(LEAF_BLOCKS)-1:0] q_leaf,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [19:0]                    out_result_address,
  output logic [20:0]                    out_used_total
);

  localparam int WB  = bba_pkg::WORD_BITS;
  localparam int WS  = bba_pkg::WORD_SHIFT;
  localparam int LXW = $clog2(LEVELS);
  localparam int LVW = $clog2(LEVELS + 1);
  localparam int LIW = $clog2(LEAF_BLOCKS);
  localparam int MW  = $clog2(MIN_BLOCK_BYTES);
  localparam int UW  = LIW + MW + 1;
  localparam int CW  = $clog2(LEAF_BLOCKS + 1);
  localparam int IXW = (LIW > WS) ? LIW : WS;

  function automatic int level_words(int l);
    return ((LEAF_BLOCKS >> l) + WB - 1) >> WS;
  endfunction

  function automatic int level_base(int l);
    int s;
    s = 0;
    for (int k = 0; k < l; k++) begin
      s += level_words(k);
    end
    return s;
  endfunction

  localparam int MAP_WORDS = level_base(LEVELS);
  localparam int TOP_BASE  = level_base(LEVELS - 1);
  localparam int CLR_LEN   = (MAP_WORDS > LEAF_BLOCKS) ? MAP_WORDS : LEAF_BLOCKS;
  localparam int MAW       = $clog2(MAP_WORDS);
  localparam int CLRW      = $clog2(CLR_LEN);

  localparam logic [LVW-1:0] LEAF_UNALLOC = '1;
  localparam logic [UW-1:0]  CAPACITY     = UW'(1) << (UW - 1);

  // Word offset of each level's bitmap in the map memory.
  logic [MAW-1:0] base_tab [LEVELS];
  for (genvar g = 0; g < LEVELS; g++) begin : g_base
    assign base_tab[g] = MAW'(level_base(g));
  end

  bba_pkg::state_t  state_r, state_nxt;
  logic [CLRW-1:0]  clr_r, clr_nxt;
  bba_pkg::cls_t    cls_r, cls_nxt;
  logic [LXW-1:0]   want_r, want_nxt;
  logic [LIW-1:0]   leaf_r, leaf_nxt;
  logic [LXW-1:0]   lvl_r, lvl_nxt;
  logic [IXW-1:0]   idx_r, idx_nxt;
  logic [MAW-1:0]   word_r, word_nxt;
  logic [UW-1:0]    used_r, used_nxt;
  logic [CW-1:0]    cnt_r [LEVELS];
  logic [CW-1:0]    cnt_nxt;
  logic             cnt_we;
  bba_pkg::status_t res_status_r, res_status_nxt;
  logic [19:0]      res_addr_r, res_addr_nxt;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [19:0]      out_addr_r;
  logic [20:0]      out_used_r;
  logic             out_load;

  // Map memory: free bitmaps of all levels.
  logic [WB-1:0]    map_mem [MAP_WORDS];
  logic [WB-1:0]    map_q_r;
  logic [MAW-1:0]   map_ra, map_wa;
  logic [WB-1:0]    map_wd;
  logic             map_we;

  // Leaf memory: level of the allocation starting at each leaf.
  logic [LVW-1:0]   leaf_mem [LEAF_BLOCKS];
  logic [LVW-1:0]   leaf_q_r;
  logic [LIW-1:0]   leaf_wa;
  logic [LVW-1:0]   leaf_wd;
  logic             leaf_we;

  // Helpers
  logic [UW-1:0]    blk_want;
  logic [UW:0]      used_sum;
  logic             over_cap;
  logic             found;
  logic [LXW-1:0]   found_lvl;
  logic [WS-1:0]    low_pos;
  logic [WS-1:0]    bpos;
  logic             ib, bb;
  logic [LXW-1:0]   fl_lvl;
  logic [UW-1:0]    blk_fl;
  logic [IXW-1:0]   split_idx;
  logic [63:0]      addr_full;

  assign blk_want = UW'(MIN_BLOCK_BYTES) << want_r;
  assign used_sum = {1'b0, used_r} + {1'b0, blk_want};
  assign over_cap = used_sum > {1'b0, CAPACITY};

  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((LXW'(l) >= want_r) && (cnt_r[l] != '0)) begin
        found     = 1'b1;
        found_lvl = LXW'(l);
      end
    end
  end

  always_comb begin
    low_pos = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (map_q_r[b]) begin
        low_pos = WS'(b);
      end
    end
  end

  assign bpos      = idx_r[WS-1:0];
  assign ib        = map_q_r[bpos];
  assign bb        = map_q_r[bpos ^ WS'(1)];
  assign fl_lvl    = LXW'(leaf_q_r);
  assign blk_fl    = UW'(MIN_BLOCK_BYTES) << fl_lvl;
  assign split_idx = (idx_r << 1) | IXW'(1);
  assign addr_full = 64'(idx_r << want_r) << MW;
  assign out_load  = !out_valid_r || !out_stall;

  assign clearing  = (state_r == bba_pkg::S_CLEAR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        if (int'(clr_r) == CLR_LEN - 1) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (q_valid) begin
          state_nxt = bba_pkg::S_CHECK;
        end
      end
      bba_pkg::S_CHECK: begin
        if (cls_r.is_free) begin
          state_nxt = cls_r.reject ? bba_pkg::S_EMIT : bba_pkg::S_FREE_LV;
        end else if (cls_r.reject || over_cap || !found) begin
          state_nxt = bba_pkg::S_EMIT;
        end else begin
          state_nxt = bba_pkg::S_SCAN_RD;
        end
      end
      bba_pkg::S_SCAN_RD: state_nxt = bba_pkg::S_SCAN_CHK;
      bba_pkg::S_SCAN_CHK: begin
        if (map_q_r == '0) begin
          state_nxt = bba_pkg::S_SCAN_RD;
        end else if (lvl_r == want_r) begin
          state_nxt = bba_pkg::S_ALLOC_FIN;
        end else begin
          state_nxt = bba_pkg::S_SPLIT;
        end
      end
      bba_pkg::S_SPLIT: begin
        if (lvl_r == want_r) begin
          state_nxt = bba_pkg::S_ALLOC_FIN;
        end
      end
      bba_pkg::S_ALLOC_FIN: state_nxt = bba_pkg::S_EMIT;
      bba_pkg::S_FREE_LV: begin
        if (leaf_q_r >= LVW'(LEVELS)) begin
          state_nxt = bba_pkg::S_EMIT;
        end else begin
          state_nxt = bba_pkg::S_MERGE_RD;
        end
      end
      bba_pkg::S_MERGE_RD: state_nxt = bba_pkg::S_MERGE_CHK;
      bba_pkg::S_MERGE_CHK: begin
        if ((lvl_r != LXW'(LEVELS - 1)) && bb) begin
          state_nxt = bba_pkg::S_MERGE_RD;
        end else begin
          state_nxt = bba_pkg::S_EMIT;
        end
      end
      bba_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_nxt        = clr_r;
    cls_nxt        = cls_r;
    want_nxt       = want_r;
    leaf_nxt       = leaf_r;
    lvl_nxt        = lvl_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    used_nxt       = used_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    cnt_we         = 1'b0;
    cnt_nxt        = cnt_r[lvl_r];
    q_pop          = 1'b0;
    map_ra         = base_tab[lvl_r] + MAW'(idx_r >> WS);
    map_we         = 1'b0;
    map_wa         = base_tab[lvl_r] + MAW'(idx_r >> WS);
    map_wd         = map_q_r;
    leaf_we        = 1'b0;
    leaf_wa        = leaf_r;
    leaf_wd        = LEAF_UNALLOC;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        clr_nxt = clr_r + CLRW'(1);
        map_we  = (int'(clr_r) < MAP_WORDS);
        map_wa  = MAW'(clr_r);
        map_wd  = (int'(clr_r) == TOP_BASE) ? WB'(1) : '0;
        leaf_we = (int'(clr_r) < LEAF_BLOCKS);
        leaf_wa = LIW'(clr_r);
      end
      bba_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          cls_nxt      = q_cls;
          want_nxt     = q_want;
          leaf_nxt     = q_leaf;
          res_addr_nxt = '0;
        end
      end
      bba_pkg::S_CHECK: begin
        if (cls_r.is_free) begin
          res_status_nxt = bba_pkg::ST_NOT_ALLOCATED;
        end else if (cls_r.reject) begin
          res_status_nxt = bba_pkg::ST_TOO_LARGE;
        end else if (over_cap) begin
          res_status_nxt = bba_pkg::ST_OVER_CAPACITY;
        end else if (!found) begin
          res_status_nxt = bba_pkg::ST_NO_BLOCK;
        end else begin
          lvl_nxt  = found_lvl;
          word_nxt = '0;
        end
      end
      bba_pkg::S_SCAN_RD: begin
        map_ra = base_tab[lvl_r] + word_r;
      end
      bba_pkg::S_SCAN_CHK: begin
        if (map_q_r == '0) begin
          word_nxt = word_r + MAW'(1);
        end else begin
          idx_nxt = IXW'((64'(word_r) << WS) | 64'(low_pos));
          map_we  = 1'b1;
          map_wa  = base_tab[lvl_r] + word_r;
          map_wd  = map_q_r & ~(WB'(1) << low_pos);
          cnt_we  = 1'b1;
          cnt_nxt = cnt_r[lvl_r] - CW'(1);
          if (lvl_r != want_r) begin
            lvl_nxt = lvl_r - LXW'(1);
          end
        end
      end
      bba_pkg::S_SPLIT: begin
        // Levels below the found one hold no free block: write the word fresh.
        idx_nxt = idx_r << 1;
        map_we  = 1'b1;
        map_wa  = base_tab[lvl_r] + MAW'(split_idx >> WS);
        map_wd  = WB'(1) << split_idx[WS-1:0];
        cnt_we  = 1'b1;
        cnt_nxt = cnt_r[lvl_r] + CW'(1);
        if (lvl_r != want_r) begin
          lvl_nxt = lvl_r - LXW'(1);
        end
      end
      bba_pkg::S_ALLOC_FIN: begin
        leaf_we        = 1'b1;
        leaf_wa        = LIW'(idx_r << want_r);
        leaf_wd        = LVW'(want_r);
        used_nxt       = used_sum[UW-1:0];
        res_status_nxt = bba_pkg::ST_OK;
        res_addr_nxt   = addr_full[19:0];
      end
      bba_pkg::S_FREE_LV: begin
        if (leaf_q_r < LVW'(LEVELS)) begin
          leaf_we        = 1'b1;
          lvl_nxt        = fl_lvl;
          idx_nxt        = IXW'(leaf_r >> fl_lvl);
          used_nxt       = (used_r >= blk_fl) ? (used_r - blk_fl) : '0;
          res_status_nxt = bba_pkg::ST_OK;
        end
      end
      bba_pkg::S_MERGE_RD: begin
        // read address defaults to the word holding idx at lvl
      end
      bba_pkg::S_MERGE_CHK: begin
        map_we = 1'b1;
        cnt_we = 1'b1;
        if ((lvl_r != LXW'(LEVELS - 1)) && bb) begin
          map_wd  = map_q_r & ~(WB'(1) << bpos) & ~(WB'(1) << (bpos ^ WS'(1)));
          cnt_nxt = cnt_r[lvl_r] - CW'(1) - CW'(ib);
          lvl_nxt = lvl_r + LXW'(1);
          idx_nxt = idx_r >> 1;
        end else begin
          map_wd  = map_q_r | (WB'(1) << bpos);
          cnt_nxt = cnt_r[lvl_r] + CW'(!ib);
        end
      end
      bba_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q_r <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    leaf_q_r <= leaf_mem[leaf_r];
  end

  always_ff @(posedge clk) begin
    cls_r        <= cls_nxt;
    want_r       <= want_nxt;
    leaf_r       <= leaf_nxt;
    lvl_r        <= lvl_nxt;
    idx_r        <= idx_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    if (state_r == bba_pkg::S_EMIT && out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_used_r   <= 21'(64'(used_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        cnt_r[l] <= (l == LEVELS - 1) ? CW'(1) : '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      if (cnt_we) begin
        cnt_r[lvl_r] <= cnt_nxt;
      end
      if (state_r == bba_pkg::S_EMIT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_used_total     = out_used_r;

endmodule

/* src/buddy_block_allocator.sv */
// Buddy block allocator.
// Input channel (in_valid / in_stall): one word per request; in_command 0
// allocates in_request_size bytes, 1 frees the block at in_block_address.
// Output channel (out_valid / out_stall): one word per request with status,
// the allocated address (zero for frees and failures) and the used total.
// Requests are classified on entry and held in a two-entry queue; a
// sequencer then walks the level bitmaps in one map memory port.
// The sequencer finishes one request before it takes the next: allocate
// scans bitmap words and splits levels, free merges levels, and rejected
// requests skip the bitmap walk.
// Reset: the bitmaps and leaf level table are swept, one entry a cycle;
// in_stall stays high through the sweep.
// A stalled result holds in the output register; the sequencer waits
// there, and the queue keeps taking requests until it is full.
module buddy_block_allocator #(
  parameter int LEAF_BLOCKS     = 1024,
  parameter int LEVELS          = 11,
  parameter int MIN_BLOCK_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_request_size,
  input  logic [19:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [19:0] out_result_address,
  output logic [20:0] out_used_total
);

  localparam int LXW = $clog2(LEVELS);
  localparam int LIW = $clog2(LEAF_BLOCKS);
  localparam int QW  = $bits(bba_pkg::cls_t) + LXW + LIW;

  bba_pkg::cls_t   f_cls, q_cls;
  logic [LXW-1:0]  f_want, q_want;
  logic [LIW-1:0]  f_leaf, q_leaf;
  logic [QW-1:0]   q_data;
  logic            q_full, q_valid, q_pop, push, clearing;

  // Front end: rounds size to a level, range-checks the free address.
  bba_front #(
    .LEAF_BLOCKS(LEAF_BLOCKS), .LEVELS(LEVELS), .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
  ) u_front (
    .command      (in_command),
    .request_size (in_request_size),
    .block_address(in_block_address),
    .cls          (f_cls),
    .want         (f_want),
    .leaf         (f_leaf)
  );

  // No intake while the reset sweep runs.
  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  bba_fifo #(.W(QW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({f_cls, f_want, f_leaf}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  assign {q_cls, q_want, q_leaf} = q_data;

  // Back end: bitmap search, split, merge and bookkeeping.
  bba_back #(
    .LEAF_BLOCKS(LEAF_BLOCKS), .LEVELS(LEVELS), .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .clearing          (clearing),
    .q_valid           (q_valid),
    .q_cls             (q_cls),
    .q_want            (q_want),
    .q_leaf            (q_leaf),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_address(out_result_address),
    .out_used_total    (out_used_total)
  );

endmodule
